/* rtl/aus_pkg.sv */
// Shared types and constants for the Annex-B access-unit splitter.
`default_nettype none

package aus_pkg;

	// Width of the offset and length fields on the result channel
	localparam int UNIT_BITS = 32;

	// Default width of the internal stream position counter
	localparam int POSITION_BITS_DEF = 32;

	// NAL header decoding
	localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
	localparam logic [4:0] NAL_SLICE     = 5'd1;
	localparam logic [4:0] NAL_SLICE_IDR = 5'd5;

	// Start-code bytes
	localparam logic [7:0] SC_ZERO_BYTE = 8'h00;
	localparam logic [7:0] SC_LAST_BYTE = 8'h01;

	// Result queue depth (power of two, at least two)
	localparam int RES_DEPTH = 4;

	// One access-unit report
	typedef struct packed {
		logic [UNIT_BITS-1:0] start;
		logic [UNIT_BITS-1:0] length;
		logic                 idr;
		logic                 fin;
		logic                 last;
		logic                 ovf;
	} aus_result_t;

	// Reports produced by one stream byte, packed from the first slot
	typedef struct packed {
		logic [1:0]  count;
		aus_result_t first;
		aus_result_t second;
	} aus_push_t;

endpackage

`default_nettype wire

/* rtl/annexb_access_unit_splitter_core.sv */
// Top level of the Annex-B access-unit splitter.
//
//   channel   direction  handshake                 payload
//   byte      in         byte_valid / byte_ready   data_byte, end_of_stream
//   unit      out        unit_valid / unit_ready   unit_start, unit_length, unit_is_idr,
//                                                   final_unit, last_of_run, position_overflow
//
// One byte is taken per cycle while the queue has room; each is registered, then queued.
// The parser stage consumes a byte only when the four-entry result queue has room
// for two reports, so a byte that yields two reports costs one extra queue slot.
// A stall on the unit side fills the queue, then deasserts byte_ready.
// Reset clears the parser state and empties the queue; end of stream does the
// same for the parser after its last byte.
`default_nettype none

module annexb_access_unit_splitter_core import aus_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 byte_valid,
	output logic                      byte_ready,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 end_of_stream,
	output logic                      unit_valid,
	input  wire logic                 unit_ready,
	output logic [UNIT_BITS-1:0]      unit_start,
	output logic [UNIT_BITS-1:0]      unit_length,
	output logic                      unit_is_idr,
	output logic                      final_unit,
	output logic                      last_of_run,
	output logic                      position_overflow
);

	aus_push_t   push;
	logic        room;
	aus_result_t head;

	aus_parse #(
		.POSITION_BITS(POSITION_BITS)
	) u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.data_byte    (data_byte),
		.end_of_stream(end_of_stream),
		.room         (room),
		.push         (push)
	);

	aus_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.unit_valid(unit_valid),
		.unit_ready(unit_ready),
		.head      (head)
	);

	// Unpack the head report onto the ports
	assign unit_start        = head.start;
	assign unit_length       = head.length;
	assign unit_is_idr       = head.idr;
	assign final_unit        = head.fin;
	assign last_of_run       = head.last;
	assign position_overflow = head.ovf;

endmodule

`default_nettype wire

/* rtl/aus_parse.sv */
// Input register, start-code and NAL header parsing, and unit boundary logic.
`default_nettype none

module aus_parse import aus_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_stream,
	input  wire logic       room,
	output aus_push_t       push
);

	// Position counter width; the limit is capped at the width of the result fields
	localparam int PW = (POSITION_BITS < UNIT_BITS) ? POSITION_BITS : UNIT_BITS;

	logic          valid_s1;
	logic [7:0]    data_s1;
	logic          eos_s1;
	logic          fire;

	logic [PW-1:0] pos_q;
	logic [1:0]    zero_run_q;
	logic          expect_hdr_q;
	logic          found_q;
	logic [PW-1:0] open_start_q;
	logic [PW-1:0] pending_q;
	logic          seen_slice_q;
	logic          open_idr_q;
	logic          ovf_q;

	logic [PW-1:0] pos_d;
	logic [1:0]    zero_run_d;
	logic          expect_hdr_d;
	logic          found_d;
	logic [PW-1:0] open_start_d;
	logic [PW-1:0] pending_d;
	logic          seen_slice_d;
	logic          open_idr_d;
	logic          ovf_d;

	logic          at_limit;
	logic [PW-1:0] end_pos;
	logic [4:0]    nal_type;
	logic          is_slice;
	logic          boundary;
	logic [PW-1:0] back;
	logic [PW-1:0] code_start;
	logic          emit_final;
	logic [PW-1:0] len_a;
	logic [PW-1:0] len_b;
	aus_result_t   res_a;
	aus_result_t   res_b;

	// Consume the held byte once the queue has room for two reports
	assign fire       = valid_s1 && room;
	assign byte_ready = !valid_s1 || fire;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			data_s1 <= data_byte;
			eos_s1  <= end_of_stream;
		end
	end

	// Position and end offset; the position sticks at all ones
	assign at_limit = &pos_q;
	assign end_pos  = at_limit ? pos_q : pos_q + PW'(1);

	assign nal_type = 5'(data_s1 & NAL_TYPE_MASK);
	assign is_slice = (nal_type == NAL_SLICE) || (nal_type == NAL_SLICE_IDR);
	assign boundary = expect_hdr_q && seen_slice_q;

	// Start code begins two or three bytes before the 01
	assign back       = (zero_run_q == 2'd3) ? PW'(3) : PW'(2);
	assign code_start = (pos_q >= back) ? pos_q - back : '0;

	// Next state for one byte
	always_comb begin
		pos_d        = end_pos;
		zero_run_d   = zero_run_q;
		expect_hdr_d = expect_hdr_q;
		found_d      = found_q;
		open_start_d = open_start_q;
		pending_d    = pending_q;
		seen_slice_d = seen_slice_q;
		open_idr_d   = open_idr_q;
		ovf_d        = ovf_q | at_limit;

		priority if (expect_hdr_q) begin
			expect_hdr_d = 1'b0;
			zero_run_d   = '0;
			seen_slice_d = is_slice;
			if (boundary) begin
				open_start_d = pending_q;
				open_idr_d   = 1'b0;
			end
			if (is_slice && nal_type == NAL_SLICE_IDR) begin
				open_idr_d = 1'b1;
			end
		end else if (data_s1 == SC_ZERO_BYTE) begin
			if (zero_run_q != 2'd3) begin
				zero_run_d = zero_run_q + 2'd1;
			end
		end else if (data_s1 == SC_LAST_BYTE && zero_run_q[1]) begin
			pending_d    = code_start;
			expect_hdr_d = 1'b1;
			zero_run_d   = '0;
			if (!found_q) begin
				found_d      = 1'b1;
				open_start_d = code_start;
			end
		end else begin
			zero_run_d = '0;
		end
	end

	assign emit_final = eos_s1 && found_d;

	// Unit lengths; a non-positive span reports one byte
	assign len_a = (pending_q > open_start_q) ? pending_q - open_start_q : PW'(1);
	assign len_b = (end_pos > open_start_d) ? end_pos - open_start_d : PW'(1);

	always_comb begin
		res_a.start  = UNIT_BITS'(open_start_q);
		res_a.length = UNIT_BITS'(len_a);
		res_a.idr    = open_idr_q;
		res_a.fin    = 1'b0;
		res_a.last   = !emit_final;
		res_a.ovf    = ovf_d;

		res_b.start  = UNIT_BITS'(open_start_d);
		res_b.length = UNIT_BITS'(len_b);
		res_b.idr    = open_idr_d;
		res_b.fin    = 1'b1;
		res_b.last   = 1'b1;
		res_b.ovf    = ovf_d;
	end

	// Pack the reports from the first slot
	always_comb begin
		push.count  = fire ? {boundary & emit_final, boundary ^ emit_final} : 2'd0;
		push.first  = boundary ? res_a : res_b;
		push.second = res_b;
	end

	// Parser state; end of stream returns everything to reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			zero_run_q   <= '0;
			expect_hdr_q <= 1'b0;
			found_q      <= 1'b0;
			open_start_q <= '0;
			pending_q    <= '0;
			seen_slice_q <= 1'b0;
			open_idr_q   <= 1'b0;
			ovf_q        <= 1'b0;
		end else if (fire) begin
			if (eos_s1) begin
				pos_q        <= '0;
				zero_run_q   <= '0;
				expect_hdr_q <= 1'b0;
				found_q      <= 1'b0;
				open_start_q <= '0;
				pending_q    <= '0;
				seen_slice_q <= 1'b0;
				open_idr_q   <= 1'b0;
				ovf_q        <= 1'b0;
			end else begin
				pos_q        <= pos_d;
				zero_run_q   <= zero_run_d;
				expect_hdr_q <= expect_hdr_d;
				found_q      <= found_d;
				open_start_q <= open_start_d;
				pending_q    <= pending_d;
				seen_slice_q <= seen_slice_d;
				open_idr_q   <= open_idr_d;
				ovf_q        <= ovf_d;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/aus_queue.sv */
// Result queue: takes up to two reports a cycle, pops one per ready cycle.
`default_nettype none

module aus_queue import aus_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  aus_push_t       push,
	output logic            room,
	output logic            unit_valid,
	input  wire logic       unit_ready,
	output aus_result_t     head
);

	localparam int AW = $clog2(RES_DEPTH);
	localparam int CW = $clog2(RES_DEPTH + 1);

	aus_result_t   mem_q [RES_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;

	assign unit_valid = (count_q != '0);
	assign pop        = unit_valid && unit_ready;
	assign room       = (count_q <= CW'(RES_DEPTH - 2));
	assign head       = mem_q[rd_ptr_q];

	// Store the packed reports
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_q + AW'(1)] <= push.second;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			count_q <= count_q + CW'(push.count) - CW'(pop);
		end
	end

endmodule

`default_nettype wire

/* rtl/aus_checker.sv */
// Port-level checks for the access-unit splitter, bound to the top level.
`default_nettype none

module aus_checker import aus_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 unit_valid,
	input wire logic                 unit_ready,
	input wire logic [UNIT_BITS-1:0] unit_start,
	input wire logic [UNIT_BITS-1:0] unit_length,
	input wire logic                 unit_is_idr,
	input wire logic                 final_unit,
	input wire logic                 last_of_run,
	input wire logic                 position_overflow
);

	// Hold a stalled report
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && !unit_ready |=> unit_valid && $stable(unit_start)
			&& $stable(unit_length) && $stable(last_of_run) && $stable(final_unit)
			&& $stable(unit_is_idr) && $stable(position_overflow))
		else $error("stalled unit beat changed");

	// A unit never reports zero bytes
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid |-> unit_length != '0)
		else $error("zero unit length");

	// The end-of-stream unit closes its byte's run
	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && final_unit |-> last_of_run)
		else $error("final unit not last of run");

	// The rest of a run is already queued
	a_run_follows: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && unit_ready && !last_of_run |=> unit_valid)
		else $error("run broken after non-last beat");

endmodule

bind annexb_access_unit_splitter_core aus_checker u_aus_checker (.*);

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for the Annex-B access-unit splitter core.
`timescale 1ns / 100ps

module tb_top;
	import aus_pkg::*;

	// Position counter width for the device under test
	localparam int POS_BITS = 16;

	// Non-slice NAL types used to build streams
	localparam logic [4:0] NAL_UNSPEC = 5'd0;
	localparam logic [4:0] NAL_SEI    = 5'd6;
	localparam logic [4:0] NAL_SPS    = 5'd7;
	localparam logic [4:0] NAL_PPS    = 5'd8;
	localparam logic [4:0] NAL_AUD    = 5'd9;

	// Tracks the stream parser state and the access units it must report
	class au_tracker;
		localparam bit [63:0] POS_LIMIT = (POS_BITS >= 32) ? 64'hFFFF_FFFF :
			(64'd1 << POS_BITS) - 64'd1;

		bit [63:0]   pos, open_start, code_start;
		bit [1:0]    zeros;
		bit          want_header, have_code, slice_open, idr_open, ovf;
		aus_result_t expected_units[$];
		int          mismatches;

		function void clear_state();
			pos = 0;
			zeros = 0;
			want_header = 0;
			have_code = 0;
			open_start = 0;
			code_start = 0;
			slice_open = 0;
			idr_open = 0;
			ovf = 0;
		endfunction

		function aus_result_t make_unit(bit [63:0] s, bit [63:0] e, bit idr, bit fin);
			aus_result_t r;
			bit [63:0]   len;
			len = (e > s) ? e - s : 64'd1;
			r.start = s[UNIT_BITS-1:0];
			r.length = len[UNIT_BITS-1:0];
			r.idr = idr;
			r.fin = fin;
			r.last = 1'b0;
			r.ovf = ovf;
			return r;
		endfunction

		// Advance the parser by one accepted byte beat and queue its units
		function void take_byte(logic [7:0] b, logic eos);
			bit [63:0]   p, stop, back;
			bit [4:0]    nal;
			bit          is_slice;
			int          n_prior;
			aus_result_t tail;
			n_prior = expected_units.size();
			p = pos;
			if (p < POS_LIMIT) begin
				pos = p + 1;
				stop = p + 1;
			end else begin
				ovf = 1'b1;
				stop = POS_LIMIT;
			end
			if (want_header) begin
				nal = 5'(b & NAL_TYPE_MASK);
				is_slice = (nal == NAL_SLICE) || (nal == NAL_SLICE_IDR);
				want_header = 0;
				zeros = 0;
				if (is_slice) begin
					if (slice_open) begin
						expected_units.push_back(make_unit(open_start, code_start,
							idr_open, 1'b0));
						open_start = code_start;
						idr_open = 0;
					end
					slice_open = 1;
					if (nal == NAL_SLICE_IDR)
						idr_open = 1;
				end else if (slice_open) begin
					expected_units.push_back(make_unit(open_start, code_start,
						idr_open, 1'b0));
					open_start = code_start;
					slice_open = 0;
					idr_open = 0;
				end
			end else if (b == SC_ZERO_BYTE) begin
				if (zeros != 2'd3)
					zeros++;
			end else if (b == SC_LAST_BYTE && zeros >= 2'd2) begin
				back = (zeros == 2'd3) ? 64'd3 : 64'd2;
				code_start = (p >= back) ? p - back : 64'd0;
				want_header = 1;
				zeros = 0;
				if (!have_code) begin
					have_code = 1;
					open_start = code_start;
				end
			end else begin
				zeros = 0;
			end
			if (eos) begin
				if (have_code)
					expected_units.push_back(make_unit(open_start, stop, idr_open, 1'b1));
				clear_state();
			end
			// Mark the closing unit of this byte
			if (expected_units.size() > n_prior) begin
				tail = expected_units.pop_back();
				tail.last = 1'b1;
				expected_units.push_back(tail);
			end
		endfunction

		function void flag(string what, aus_result_t want, aus_result_t got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t %s: expected start=%0d len=%0d idr=%0b fin=%0b last=%0b ovf=%0b",
					$time, what, want.start, want.length, want.idr, want.fin, want.last,
					want.ovf);
				$display("    got start=%0d len=%0d idr=%0b fin=%0b last=%0b ovf=%0b",
					got.start, got.length, got.idr, got.fin, got.last, got.ovf);
			end
		endfunction

		// Compare one accepted unit beat with the oldest expected unit
		function void match_unit(aus_result_t got);
			aus_result_t want;
			if (expected_units.size() == 0) begin
				flag("unit with none expected", '0, got);
			end else begin
				want = expected_units.pop_front();
				if (got.start !== want.start || got.length !== want.length ||
						got.idr !== want.idr || got.fin !== want.fin ||
						got.last !== want.last || got.ovf !== want.ovf)
					flag("unit mismatch", want, got);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 byte_valid;
	logic                 byte_ready;
	logic [7:0]           data_byte;
	logic                 end_of_stream;
	logic                 unit_valid;
	logic                 unit_ready;
	logic [UNIT_BITS-1:0] unit_start;
	logic [UNIT_BITS-1:0] unit_length;
	logic                 unit_is_idr;
	logic                 final_unit;
	logic                 last_of_run;
	logic                 position_overflow;

	au_tracker  tracker = new();
	logic [7:0] stream_q[$];
	bit         idling;
	bit         hold_req;
	int         sent;

	annexb_access_unit_splitter_core #(.POSITION_BITS(POS_BITS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.data_byte(data_byte),
		.end_of_stream(end_of_stream),
		.unit_valid(unit_valid),
		.unit_ready(unit_ready),
		.unit_start(unit_start),
		.unit_length(unit_length),
		.unit_is_idr(unit_is_idr),
		.final_unit(final_unit),
		.last_of_run(last_of_run),
		.position_overflow(position_overflow)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watch both channels; a byte beat is noted before any unit beat of the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && byte_ready)
				tracker.take_byte(data_byte, end_of_stream);
			if (unit_valid && unit_ready)
				tracker.match_unit('{start: unit_start, length: unit_length,
					idr: unit_is_idr, fin: final_unit, last: last_of_run,
					ovf: position_overflow});
		end
	end

	// Unit side: random stall bursts, one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				unit_ready <= 1'b0;
				hold_req = 1'b0;
				repeat (300) @(negedge clk);
			end else if (idling && $urandom_range(0, 7) == 0) begin
				unit_ready <= 1'b0;
				repeat ($urandom_range(0, 12)) @(negedge clk);
			end else begin
				unit_ready <= 1'b1;
			end
		end
	end

	// Offer one byte beat and hold it until taken; entered and left just after a falling edge
	task automatic send_byte(input logic [7:0] b, input logic eos);
		if (idling && $urandom_range(0, 7) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= b;
		end_of_stream <= eos;
		@(posedge clk);
		while (!byte_ready)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	// Send the built stream, flagging end of stream on its last byte
	task automatic send_stream();
		int i;
		for (i = 0; i < stream_q.size(); i++)
			send_byte(stream_q[i], i == stream_q.size() - 1);
		stream_q.delete();
	endtask

	function automatic void push_byte(logic [7:0] b);
		stream_q.push_back(b);
	endfunction

	function automatic void push_code(int extra_zeros);
		repeat (extra_zeros) push_byte(SC_ZERO_BYTE);
		push_byte(SC_ZERO_BYTE);
		push_byte(SC_ZERO_BYTE);
		push_byte(SC_LAST_BYTE);
	endfunction

	function automatic logic [7:0] random_header();
		logic [4:0] nal;
		case ($urandom_range(0, 9))
			0, 1, 2: nal = NAL_SLICE;
			3, 4: nal = NAL_SLICE_IDR;
			5: nal = NAL_SEI;
			6: nal = NAL_SPS;
			7: nal = NAL_PPS;
			8: nal = NAL_AUD;
			default: nal = 5'($urandom_range(0, 31));
		endcase
		return {3'($urandom_range(0, 7)), nal};
	endfunction

	// Start code, header and payload; payload zeros may form stray codes
	function automatic void push_nal(logic [7:0] hdr, int len);
		push_code(($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
		push_byte(hdr);
		repeat (len)
			push_byte(($urandom_range(0, 3) == 0) ? SC_ZERO_BYTE : 8'($urandom_range(1, 255)));
	endfunction

	// Mostly well-formed streams with random content, some noise and cut-short ones
	task automatic random_stream();
		int kind;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(1, 40))
				case ($urandom_range(0, 4))
					0, 1: push_byte(SC_ZERO_BYTE);
					2: push_byte(SC_LAST_BYTE);
					default: push_byte(8'($urandom_range(0, 255)));
				endcase
		end else begin
			repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(1, 255)));
			repeat ($urandom_range(1, 6)) push_nal(random_header(), $urandom_range(0, 10));
			if (kind == 1)
				push_code($urandom_range(0, 1));
			else if (kind == 2)
				stream_q = stream_q[0:$urandom_range(0, stream_q.size() - 1)];
		end
		send_stream();
	endtask

	initial begin
		arst_n = 1'b0;
		byte_valid = 1'b0;
		data_byte = 8'h00;
		end_of_stream = 1'b0;
		unit_ready = 1'b0;
		idling = 1'b0;
		hold_req = 1'b0;
		sent = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// No start code at all: nothing reported
		push_byte(8'hFF);
		push_byte(SC_ZERO_BYTE);
		push_byte(SC_LAST_BYTE);
		send_stream();

		// Long zero run, slice after slice, non-slice after slice, zero and one as
		// header bytes, stream ending on a bare start code
		push_code(2);
		push_byte({3'b011, NAL_SLICE_IDR});
		push_code(0);
		push_byte({3'b010, NAL_SLICE});
		push_code(0);
		push_byte({3'b000, NAL_UNSPEC});
		push_code(0);
		push_byte({3'b000, NAL_SLICE});
		push_code(0);
		send_stream();

		// Two units closed by one byte
		push_code(0);
		push_byte({3'b111, NAL_SLICE});
		push_code(1);
		push_byte({3'b000, NAL_SEI});
		send_stream();

		// Random streams with idling on both sides
		idling = 1'b1;
		while (sent < 350)
			random_stream();

		// Long hold-off on the unit side while bytes keep coming
		hold_req = 1'b1;
		while (sent < 650)
			random_stream();

		// Full rate to the end
		idling = 1'b0;
		while (sent < 920)
			random_stream();
		byte_valid <= 1'b0;

		while (tracker.expected_units.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.expected_units.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	// Hard stop well past the slowest correct run
	initial begin
		#4_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
